FILE: src/hcll_pkg.sv
// Shared constants, types and state codes of the Huffman code length limiter.
`default_nettype none

package hcll_pkg;

    // Default configuration
    localparam int DEF_MAX_SYMBOLS    = 256;
    localparam int DEF_MAX_TREE_DEPTH = 32;
    localparam int DEF_LENGTH_LIMIT   = 16;

    // Fixed field widths
    localparam int FREQ_W   = 14;
    localparam int WEIGHT_W = 23;
    localparam int DEPTH_W  = 6;
    localparam int LINK_W   = 10;
    localparam int COUNT_W  = 9;
    localparam int LEN_W    = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [LINK_W-1:0] LINK_EMPTY = '1;

    // One tree node as stored in the node memory
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [DEPTH_W-1:0]  depth;
        logic [LINK_W-1:0]   link;
    } node_word_t;

    localparam int NODE_WORD_W = WEIGHT_W + DEPTH_W + LINK_W;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_END,
        ST_WALK_START,
        ST_WALK_STEP,
        ST_HB_RD,
        ST_HB_CHK,
        ST_HB_WR,
        ST_AD_RI,
        ST_AD_CI,
        ST_AD_LOOP,
        ST_AD_RJ,
        ST_AD_CJ,
        ST_FD_RD,
        ST_FD_WR,
        ST_FD_ZERO,
        ST_UP_I,
        ST_UP_RP,
        ST_UP_WP,
        ST_UP_RN,
        ST_UP_WN,
        ST_UP_WJ,
        ST_FN_RD,
        ST_FN_CHK,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT_SHOW
    } state_t;

endpackage

`default_nettype wire

FILE: src/hcll_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module hcll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/huffman_code_length_limiter.sv
// Top level of the Huffman code length limiter (JPEG style 16-bit limit).
//
// Symbol frequencies stream in one item per cycle into the node memory; the
// item with tlast set closes the table and starts the build, and tready stays
// low until the last count has been taken. A hidden symbol of weight 1 is
// added. The build then runs on two memories: a clearing sweep, then for every
// merge a full scan of the node memory plus a walk over the nodes of the two
// merged chains, then a histogram pass over the nodes, the length limiting
// pass on the histogram memory and the LENGTH_LIMIT results. The run time is
// set by the merge scans over the node memory read port. Results are the code
// counts for lengths 1 to LENGTH_LIMIT, the last one with tlast.
`default_nettype none

module huffman_code_length_limiter
    import hcll_pkg::*;
#(
    parameter int MAX_SYMBOLS    = DEF_MAX_SYMBOLS,
    parameter int MAX_TREE_DEPTH = DEF_MAX_TREE_DEPTH,
    parameter int LENGTH_LIMIT   = DEF_LENGTH_LIMIT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [13:0] frequency, rest zero
    input  wire logic                   s_axis_tlast,   // last_symbol
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // [4:0] code_length, [13:5] symbol_count
    output logic                        m_axis_tlast    // last_length
);

    localparam int NODE_COUNT = MAX_SYMBOLS + 1;
    localparam int HIST_DEPTH = MAX_TREE_DEPTH + 1;
    localparam int DEPTH_CAP  = (MAX_TREE_DEPTH < 63) ? MAX_TREE_DEPTH : 63;
    localparam int CLR_LEN    = (NODE_COUNT > HIST_DEPTH) ? NODE_COUNT : HIST_DEPTH;
    localparam int NW = $clog2(NODE_COUNT);
    localparam int HW = $clog2(HIST_DEPTH);
    localparam int CW = $clog2(CLR_LEN + 1);

    state_t state_reg, state_next;

    logic [NW-1:0]       load_index_reg, load_index_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                b1_v_reg, b1_v_next, b2_v_reg, b2_v_next;
    logic [NW-1:0]       b1_idx_reg, b1_idx_next, b2_idx_reg, b2_idx_next;
    logic [WEIGHT_W-1:0] b1_w_reg, b1_w_next, b2_w_reg, b2_w_next;
    logic [WEIGHT_W-1:0] sum_reg, sum_next;
    logic [NW-1:0]       walk_n_reg, walk_n_next;
    logic                walk_b_reg, walk_b_next;
    logic                walk_first_reg, walk_first_next;
    logic [HW-1:0]       hd_reg, hd_next;
    logic [HW-1:0]       i_reg, i_next, j_reg, j_next;
    logic [COUNT_W-1:0]  hi_reg, hi_next, hj_reg, hj_next;
    logic [LEN_W-1:0]    k_reg, k_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // Memory ports
    logic               node_we;
    logic [NW-1:0]      node_waddr, node_raddr;
    node_word_t         node_wdata, node_rdata;
    logic               hist_we;
    logic [HW-1:0]      hist_waddr, hist_raddr;
    logic [COUNT_W-1:0] hist_wdata, hist_rdata;

    logic               in_acc, out_acc;
    logic [NW-1:0]      proc_idx;
    logic [DEPTH_W-1:0] depth_sat;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign proc_idx  = NW'(cnt_reg - CW'(1));
    assign depth_sat = (node_rdata.depth < DEPTH_W'(DEPTH_CAP))
                       ? node_rdata.depth + DEPTH_W'(1) : node_rdata.depth;

    hcll_ram #(
        .WIDTH (NODE_WORD_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    hcll_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (in_acc && s_axis_tlast)
                    state_next = ST_CLEAR;
            ST_CLEAR:
                if (cnt_reg == CW'(CLR_LEN - 1))
                    state_next = ST_SCAN;
            ST_SCAN:
                if (cnt_reg == CW'(NODE_COUNT))
                    state_next = ST_SCAN_END;
            ST_SCAN_END:
                state_next = (b1_v_reg && b2_v_reg) ? ST_WALK_START : ST_HB_RD;
            ST_WALK_START:
                state_next = ST_WALK_STEP;
            ST_WALK_STEP:
                if (node_rdata.link == LINK_EMPTY)
                    state_next = walk_b_reg ? ST_SCAN : ST_WALK_START;
            ST_HB_RD:
                state_next = ST_HB_CHK;
            ST_HB_CHK:
                if (node_rdata.depth != '0)
                    state_next = ST_HB_WR;
                else if (cnt_reg == CW'(NODE_COUNT - 1))
                    state_next = ST_AD_RI;
                else
                    state_next = ST_HB_RD;
            ST_HB_WR:
                state_next = (cnt_reg == CW'(NODE_COUNT - 1)) ? ST_AD_RI : ST_HB_RD;
            ST_AD_RI:
                state_next = ST_AD_CI;
            ST_AD_CI:
                state_next = ST_AD_LOOP;
            ST_AD_LOOP:
                if (hi_reg != '0)
                    state_next = ST_AD_RJ;
                else if (i_reg == HW'(LENGTH_LIMIT + 1))
                    state_next = ST_FN_RD;
                else
                    state_next = ST_AD_RI;
            ST_AD_RJ:
                state_next = ST_AD_CJ;
            ST_AD_CJ:
                if (hist_rdata != '0)
                    state_next = ST_UP_I;
                else if (j_reg == HW'(1))
                    state_next = ST_FD_RD;
                else
                    state_next = ST_AD_RJ;
            ST_FD_RD:    state_next = ST_FD_WR;
            ST_FD_WR:    state_next = ST_FD_ZERO;
            ST_FD_ZERO:  state_next = ST_AD_LOOP;
            ST_UP_I:     state_next = ST_UP_RP;
            ST_UP_RP:    state_next = ST_UP_WP;
            ST_UP_WP:    state_next = ST_UP_RN;
            ST_UP_RN:    state_next = ST_UP_WN;
            ST_UP_WN:    state_next = ST_UP_WJ;
            ST_UP_WJ:    state_next = ST_AD_LOOP;
            ST_FN_RD:    state_next = ST_FN_CHK;
            ST_FN_CHK:
                if (hist_rdata != '0 || i_reg == HW'(1))
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_FN_RD;
            ST_OUT_RD:   state_next = ST_OUT_CAP;
            ST_OUT_CAP:  state_next = ST_OUT_SHOW;
            ST_OUT_SHOW:
                if (out_acc)
                    state_next = (k_reg == LEN_W'(LENGTH_LIMIT)) ? ST_LOAD : ST_OUT_RD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        load_index_next = load_index_reg;
        cnt_next        = cnt_reg;
        b1_v_next       = b1_v_reg;
        b2_v_next       = b2_v_reg;
        b1_idx_next     = b1_idx_reg;
        b2_idx_next     = b2_idx_reg;
        b1_w_next       = b1_w_reg;
        b2_w_next       = b2_w_reg;
        sum_next        = sum_reg;
        walk_n_next     = walk_n_reg;
        walk_b_next     = walk_b_reg;
        walk_first_next = walk_first_reg;
        hd_next         = hd_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        hi_next         = hi_reg;
        hj_next         = hj_reg;
        k_next          = k_reg;
        out_count_next  = out_count_reg;

        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '{weight: '0, depth: '0, link: LINK_EMPTY};
        node_raddr = '0;
        hist_we    = 1'b0;
        hist_waddr = '0;
        hist_wdata = '0;
        hist_raddr = '0;

        case (state_reg)
            // Load one frequency per item; extra symbols are dropped
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (load_index_reg < NW'(MAX_SYMBOLS))
                    begin
                        node_we         = 1'b1;
                        node_waddr      = load_index_reg;
                        node_wdata.weight = WEIGHT_W'(s_axis_tdata[FREQ_W-1:0]);
                        load_index_next = load_index_reg + NW'(1);
                    end
                    cnt_next = '0;
                end
            end

            // Zero unloaded weights, place the reserved symbol, clear histogram
            ST_CLEAR:
            begin
                if (cnt_reg >= CW'(load_index_reg) && cnt_reg < CW'(NODE_COUNT))
                begin
                    node_we    = 1'b1;
                    node_waddr = cnt_reg[NW-1:0];
                    node_wdata.weight = (cnt_reg == CW'(MAX_SYMBOLS))
                                        ? WEIGHT_W'(1) : '0;
                end
                if (cnt_reg < CW'(HIST_DEPTH))
                begin
                    hist_we    = 1'b1;
                    hist_waddr = cnt_reg[HW-1:0];
                end
                if (cnt_reg == CW'(CLR_LEN - 1))
                begin
                    cnt_next  = '0;
                    b1_v_next = 1'b0;
                    b2_v_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            // Find the two least nonzero weights, highest index on ties
            ST_SCAN:
            begin
                node_raddr = (cnt_reg < CW'(NODE_COUNT)) ? cnt_reg[NW-1:0] : '0;
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg != '0 && node_rdata.weight != '0)
                begin
                    if (!b1_v_reg || node_rdata.weight <= b1_w_reg)
                    begin
                        b2_v_next   = b1_v_reg;
                        b2_idx_next = b1_idx_reg;
                        b2_w_next   = b1_w_reg;
                        b1_v_next   = 1'b1;
                        b1_idx_next = proc_idx;
                        b1_w_next   = node_rdata.weight;
                    end
                    else if (!b2_v_reg || node_rdata.weight <= b2_w_reg)
                    begin
                        b2_v_next   = 1'b1;
                        b2_idx_next = proc_idx;
                        b2_w_next   = node_rdata.weight;
                    end
                end
            end

            ST_SCAN_END:
            begin
                sum_next        = b1_w_reg + b2_w_reg;
                walk_n_next     = b1_idx_reg;
                walk_b_next     = 1'b0;
                walk_first_next = 1'b1;
                cnt_next        = '0;
            end

            ST_WALK_START:
            begin
                node_raddr = walk_n_reg;
            end

            // Deepen one chain node per cycle; the merge weights ride along
            ST_WALK_STEP:
            begin
                node_we           = 1'b1;
                node_waddr        = walk_n_reg;
                node_wdata.depth  = depth_sat;
                node_wdata.link   = node_rdata.link;
                node_wdata.weight = node_rdata.weight;
                if (walk_first_reg)
                    node_wdata.weight = walk_b_reg ? '0 : sum_reg;
                walk_first_next = 1'b0;
                if (node_rdata.link == LINK_EMPTY)
                begin
                    if (!walk_b_reg)
                    begin
                        node_wdata.link = LINK_W'(b2_idx_reg);
                        walk_n_next     = b2_idx_reg;
                        walk_b_next     = 1'b1;
                        walk_first_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next  = '0;
                        b1_v_next = 1'b0;
                        b2_v_next = 1'b0;
                    end
                end
                else
                begin
                    walk_n_next = node_rdata.link[NW-1:0];
                    node_raddr  = node_rdata.link[NW-1:0];
                end
            end

            // Count symbols per depth
            ST_HB_RD:
            begin
                node_raddr = cnt_reg[NW-1:0];
            end

            ST_HB_CHK:
            begin
                hd_next    = HW'(node_rdata.depth);
                hist_raddr = HW'(node_rdata.depth);
                if (node_rdata.depth == '0)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    i_next   = HW'(MAX_TREE_DEPTH);
                end
            end

            ST_HB_WR:
            begin
                hist_we    = 1'b1;
                hist_waddr = hd_reg;
                hist_wdata = hist_rdata + COUNT_W'(1);
                cnt_next   = cnt_reg + CW'(1);
                i_next     = HW'(MAX_TREE_DEPTH);
            end

            // Length limiting, longest lengths first
            ST_AD_RI:
            begin
                hist_raddr = i_reg;
            end

            ST_AD_CI:
            begin
                hi_next = hist_rdata;
            end

            ST_AD_LOOP:
            begin
                if (hi_reg != '0)
                    j_next = i_reg - HW'(2);
                else if (i_reg == HW'(LENGTH_LIMIT + 1))
                    i_next = HW'(LENGTH_LIMIT);
                else
                    i_next = i_reg - HW'(1);
            end

            ST_AD_RJ:
            begin
                hist_raddr = j_reg;
            end

            ST_AD_CJ:
            begin
                hj_next = hist_rdata;
                if (hist_rdata == '0 && j_reg != HW'(1))
                    j_next = j_reg - HW'(1);
            end

            // No shorter prefix: fold the rest into the next shorter length
            ST_FD_RD:
            begin
                hist_raddr = i_reg - HW'(1);
            end

            ST_FD_WR:
            begin
                hist_we    = 1'b1;
                hist_waddr = i_reg - HW'(1);
                hist_wdata = hist_rdata + hi_reg;
            end

            ST_FD_ZERO:
            begin
                hist_we    = 1'b1;
                hist_waddr = i_reg;
                hi_next    = '0;
            end

            // Move a pair up: i -= 2, i-1 += 1, j+1 += 2, j -= 1
            ST_UP_I:
            begin
                hist_we    = 1'b1;
                hist_waddr = i_reg;
                hist_wdata = (hi_reg >= COUNT_W'(2)) ? hi_reg - COUNT_W'(2) : '0;
                hi_next    = hist_wdata;
            end

            ST_UP_RP:
            begin
                hist_raddr = i_reg - HW'(1);
            end

            ST_UP_WP:
            begin
                hist_we    = 1'b1;
                hist_waddr = i_reg - HW'(1);
                hist_wdata = hist_rdata + COUNT_W'(1);
            end

            ST_UP_RN:
            begin
                hist_raddr = j_reg + HW'(1);
            end

            ST_UP_WN:
            begin
                hist_we    = 1'b1;
                hist_waddr = j_reg + HW'(1);
                hist_wdata = hist_rdata + COUNT_W'(2);
            end

            ST_UP_WJ:
            begin
                hist_we    = 1'b1;
                hist_waddr = j_reg;
                hist_wdata = hj_reg - COUNT_W'(1);
            end

            // Drop the reserved symbol from the longest length in use
            ST_FN_RD:
            begin
                hist_raddr = i_reg;
            end

            ST_FN_CHK:
            begin
                k_next = LEN_W'(1);
                if (hist_rdata != '0)
                begin
                    hist_we    = 1'b1;
                    hist_waddr = i_reg;
                    hist_wdata = hist_rdata - COUNT_W'(1);
                end
                else if (i_reg != HW'(1))
                begin
                    i_next = i_reg - HW'(1);
                end
            end

            // Result output
            ST_OUT_RD:
            begin
                hist_raddr = HW'(k_reg);
            end

            ST_OUT_CAP:
            begin
                out_count_next = hist_rdata;
            end

            ST_OUT_SHOW:
            begin
                if (out_acc)
                begin
                    if (k_reg == LEN_W'(LENGTH_LIMIT))
                        load_index_next = '0;
                    else
                        k_next = k_reg + LEN_W'(1);
                end
            end

            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_index_reg <= '0;
            cnt_reg        <= '0;
            b1_v_reg       <= 1'b0;
            b2_v_reg       <= 1'b0;
            walk_b_reg     <= 1'b0;
            walk_first_reg <= 1'b0;
            k_reg          <= LEN_W'(1);
        end
        else
        begin
            state_reg      <= state_next;
            load_index_reg <= load_index_next;
            cnt_reg        <= cnt_next;
            b1_v_reg       <= b1_v_next;
            b2_v_reg       <= b2_v_next;
            walk_b_reg     <= walk_b_next;
            walk_first_reg <= walk_first_next;
            k_reg          <= k_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        b1_idx_reg    <= b1_idx_next;
        b2_idx_reg    <= b2_idx_next;
        b1_w_reg      <= b1_w_next;
        b2_w_reg      <= b2_w_next;
        sum_reg       <= sum_next;
        walk_n_reg    <= walk_n_next;
        hd_reg        <= hd_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        hi_reg        <= hi_next;
        hj_reg        <= hj_next;
        out_count_reg <= out_count_next;
    end

    // Ports
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_OUT_SHOW);
    assign m_axis_tdata  = OUT_TDATA_W'({out_count_reg, k_reg});
    assign m_axis_tlast  = (k_reg == LEN_W'(LENGTH_LIMIT));

    // Loading and result output never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output sides active together");

    // After the final length the block is ready for a new table
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_axis_tlast) |=> (s_axis_tready && load_index_reg == '0))
        else $error("block did not return to loading");

    // A chain never links back to the node being written
    a_chain_acyclic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_STEP && node_rdata.link != LINK_EMPTY)
            |-> (node_raddr != node_waddr))
        else $error("chain walk read hits its own write");

    // Histogram writes stay within the depth range
    a_hist_range: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |-> (hist_waddr <= HW'(MAX_TREE_DEPTH)))
        else $error("histogram write out of range");

endmodule

`default_nettype wire
